// ===== design/toy_register_machine_execute_macros.svh =====
// assertion macros shared by the register machine rtl
// no dependencies
`ifndef TOY_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);
`define ASSERT_NEVER(lbl, ck, rs, expr, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(lbl, ck, rs, prop, msg)
`define ASSERT_NEVER(lbl, ck, rs, expr, msg)
`endif
`endif

// ===== design/trme_pkg.sv =====
// shared types and constants of the register machine execute block
// no dependencies
package trme_pkg;
  localparam int DATA_WORDS_DEF = 1024;
  localparam int REGISTER_COUNT_DEF = 11;
  localparam int PROGRAM_WORDS = 1024;
  localparam int PLEN_W = 11;
  localparam int PC_W = 10;
  localparam int XLEN = 32;
  localparam int IN_W = 72;
  localparam int OUT_W = 80;
  localparam logic REG_PROGRAM_LENGTH = 1'b0;

  typedef enum logic [3:0] {
    OP_NOP = 4'd0, OP_ADD = 4'd1, OP_SUB = 4'd2, OP_DIV = 4'd3, OP_MUL = 4'd4,
    OP_MOV = 4'd5, OP_BRZ = 4'd6, OP_BRNZ = 4'd7, OP_IBRZ = 4'd8, OP_BLZ = 4'd9,
    OP_LOADM = 4'd10, OP_STOREM = 4'd11, OP_LOADI = 4'd12, OP_WRITE = 4'd13,
    OP_READ = 4'd14, OP_EXIT = 4'd15
  } op_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_DIV0 = 2'd1, ST_BAD_REG = 2'd2, ST_BAD_ADDR = 2'd3
  } stat_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic rd;
    logic ex;
    logic div_start;
    logic wb;
  } ctl_t;

  typedef struct packed {
    logic clr_last;
    logic need_div;
    logic div_done;
    logic out_free;
  } sts_t;
endpackage

// ===== design/trme_div.sv =====
// iterative signed 32-bit divider, one quotient bit per cycle
// depends on trme_pkg
module trme_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [trme_pkg::XLEN-1:0] dividend,
  input  logic [trme_pkg::XLEN-1:0] divisor,
  output logic                    done,
  output logic [trme_pkg::XLEN-1:0] quotient
);
  import trme_pkg::*;

  localparam int CNT_W = $clog2(XLEN);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [XLEN-1:0]  rem;
  logic [XLEN-1:0]  quo;
  logic [XLEN-1:0]  ub;
  logic             neg;
  logic [XLEN:0]    shifted;
  logic [XLEN+1:0]  trial;

  assign shifted = {rem, quo[XLEN-1]};
  assign trial = {1'b0, shifted} - {2'b00, ub};
  assign quotient = neg ? (XLEN'(0) - quo) : quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= '0;
      end else if (busy) begin
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(XLEN - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend[XLEN-1] ? (XLEN'(0) - dividend) : dividend;
      ub <= divisor[XLEN-1] ? (XLEN'(0) - divisor) : divisor;
      neg <= dividend[XLEN-1] ^ divisor[XLEN-1];
      rem <= '0;
    end else if (busy) begin
      if (!trial[XLEN+1]) begin
        rem <= trial[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b1};
      end else begin
        rem <= shifted[XLEN-1:0];
        quo <= {quo[XLEN-2:0], 1'b0};
      end
    end
  end
endmodule

// ===== design/trme_dp.sv =====
// datapath: register file, data memory, alu, machine state and output register
// depends on trme_pkg and trme_div
module trme_dp #(
  parameter int DATA_WORDS = trme_pkg::DATA_WORDS_DEF,
  parameter int REGISTER_COUNT = trme_pkg::REGISTER_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  trme_pkg::ctl_t             ctl,
  output trme_pkg::sts_t             sts,
  input  logic [trme_pkg::PLEN_W-1:0] program_length,
  input  logic [trme_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [trme_pkg::OUT_W-1:0] m_tdata
);
  import trme_pkg::*;

  localparam int AW = $clog2(DATA_WORDS);
  localparam int RW = (REGISTER_COUNT > 2) ? $clog2(REGISTER_COUNT) : 1;

  // input item
  op_t             cmd;
  logic [3:0]      treg;
  logic [XLEN-1:0] src;
  logic [XLEN-1:0] rdv;

  // storage
  logic [XLEN-1:0]           rf [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] rf_vld;
  logic [XLEN-1:0]           mem [DATA_WORDS];
  logic [AW-1:0]             clr_addr;

  // machine state
  logic [PC_W-1:0] pc;
  logic            stopped;
  stat_t           status;
  logic [XLEN-1:0] count;

  // read stage
  logic [XLEN-1:0] ra;
  logic [XLEN-1:0] rb;
  logic [XLEN-1:0] md;

  // execute stage results
  logic [PC_W-1:0] pc_next;
  logic            stop_next;
  stat_t           stat_next;
  logic [XLEN-1:0] res;
  logic            rf_we;
  logic            mem_we;
  logic            wv;
  logic            is_div;
  logic            do_op;

  logic            div_done;
  logic [XLEN-1:0] div_q;

  // execute logic
  logic [PLEN_W-1:0] len;
  logic              oor;
  logic              exec;
  logic              t_bad;
  logic              s_bad;
  logic              a_bad;
  stat_t             st_f;
  logic              op_ok;
  logic              take;
  logic signed [XLEN+1:0] nxt;
  logic              leave;
  logic [XLEN-1:0]   res_c;
  logic              rf_we_c;
  logic [RW-1:0]     ti;
  logic [RW-1:0]     si;
  logic              t_ok;
  logic              s_ok;

  assign ti = treg[RW-1:0];
  assign si = src[RW-1:0];
  assign t_ok = {28'd0, treg} < XLEN'(REGISTER_COUNT);
  assign s_ok = src < XLEN'(REGISTER_COUNT);

  always_comb begin
    len = (program_length < PLEN_W'(PROGRAM_WORDS)) ? program_length : PLEN_W'(PROGRAM_WORDS);
    oor = !stopped && ({1'b0, pc} >= len);
    exec = !stopped && !oor;
    t_bad = (cmd != OP_NOP) && (cmd != OP_EXIT) && !t_ok;
    s_bad = (cmd inside {[OP_ADD:OP_MOV]}) && !s_ok;
    a_bad = (cmd inside {OP_LOADM, OP_STOREM}) && (src >= XLEN'(DATA_WORDS));
    if (t_bad || s_bad) st_f = ST_BAD_REG;
    else if (a_bad) st_f = ST_BAD_ADDR;
    else if ((cmd == OP_DIV) && (rb == '0)) st_f = ST_DIV0;
    else st_f = ST_OK;
    op_ok = exec && (st_f == ST_OK) && (cmd != OP_EXIT);
    case (cmd)
      OP_BRZ, OP_IBRZ: take = (ra == '0);
      OP_BRNZ:         take = (ra != '0);
      OP_BLZ:          take = ra[XLEN-1];
      default:         take = 1'b0;
    endcase
    if (take && (cmd == OP_IBRZ))
      nxt = (XLEN+2)'(signed'(src));
    else if (take)
      nxt = signed'({{(XLEN+2-PC_W){1'b0}}, pc}) + (XLEN+2)'(signed'(src));
    else
      nxt = signed'({{(XLEN+2-PC_W){1'b0}}, pc}) + (XLEN+2)'(1);
    leave = nxt[XLEN+1] || (nxt >= signed'((XLEN+2)'(len)));
    rf_we_c = 1'b1;
    case (cmd)
      OP_ADD:   res_c = ra + rb;
      OP_SUB:   res_c = ra - rb;
      OP_MUL:   res_c = XLEN'(ra * rb);
      OP_MOV:   res_c = rb;
      OP_LOADM: res_c = md;
      OP_LOADI: res_c = src;
      OP_READ:  res_c = rdv;
      OP_DIV:   res_c = '0;
      default: begin
        res_c = '0;
        rf_we_c = 1'b0;
      end
    endcase
  end

  assign sts.need_div = op_ok && (cmd == OP_DIV);
  assign sts.div_done = div_done;
  assign sts.out_free = !m_tvalid || m_tready;
  assign sts.clr_last = clr_addr == AW'(DATA_WORDS - 1);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd <= op_t'(s_tdata[3:0]);
      treg <= s_tdata[7:4];
      src <= s_tdata[39:8];
      rdv <= s_tdata[71:40];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) clr_addr <= '0;
    else if (ctl.clr) clr_addr <= clr_addr + AW'(1);
  end

  // data memory: clear sweep or store, registered read
  always_ff @(posedge clk) begin
    if (ctl.clr) mem[clr_addr] <= '0;
    else if (ctl.wb && mem_we) mem[src[AW-1:0]] <= ra;
    if (ctl.rd) md <= mem[src[AW-1:0]];
  end

  // register file, registered two-port read
  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      ra <= (t_ok && rf_vld[ti]) ? rf[ti] : '0;
      rb <= (s_ok && rf_vld[si]) ? rf[si] : '0;
    end
    if (ctl.wb && rf_we) rf[ti] <= is_div ? div_q : res;
  end

  always_ff @(posedge clk) begin
    if (rst) rf_vld <= '0;
    else if (ctl.wb && rf_we) rf_vld[ti] <= 1'b1;
  end

  always_ff @(posedge clk) begin
    if (ctl.ex) begin
      do_op <= op_ok;
      pc_next <= (op_ok && !leave) ? nxt[PC_W-1:0] : pc;
      stop_next <= !(op_ok && !leave);
      if (stopped) stat_next <= status;
      else if (exec && (st_f != ST_OK)) stat_next <= st_f;
      else stat_next <= ST_OK;
      res <= res_c;
      rf_we <= op_ok && rf_we_c;
      mem_we <= op_ok && (cmd == OP_STOREM);
      wv <= op_ok && (cmd == OP_WRITE);
      is_div <= cmd == OP_DIV;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= '0;
      stopped <= 1'b0;
      status <= ST_OK;
      count <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (ctl.wb) begin
        pc <= pc_next;
        stopped <= stop_next;
        status <= stat_next;
        count <= count + XLEN'(do_op);
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wb) begin
      m_tdata <= {2'b00, count + XLEN'(do_op), stat_next, stop_next,
                  wv ? ra : XLEN'(0), wv, pc_next};
    end
  end

  trme_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (ra),
    .divisor  (rb),
    .done     (div_done),
    .quotient (div_q)
  );
endmodule

// ===== design/trme_ctrl.sv =====
// controller state machine: memory clear sweep and per-item sequencing
// depends on trme_pkg and the assertion macros
`include "toy_register_machine_execute_macros.svh"
module trme_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  output trme_pkg::ctl_t ctl,
  input  trme_pkg::sts_t sts
);
  import trme_pkg::*;

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_RD    = 6'b000100,
    S_EX    = 6'b001000,
    S_DV    = 6'b010000,
    S_WB    = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  assign s_tready = state == S_IDLE;

  always_comb begin
    state_next = state;
    ctl = '0;
    case (state)
      S_CLEAR: begin
        ctl.clr = 1'b1;
        if (sts.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        ctl.load = s_tvalid;
        if (s_tvalid) state_next = S_RD;
      end
      S_RD: begin
        ctl.rd = 1'b1;
        state_next = S_EX;
      end
      S_EX: begin
        ctl.ex = 1'b1;
        ctl.div_start = sts.need_div;
        state_next = sts.need_div ? S_DV : S_WB;
      end
      S_DV: begin
        if (sts.div_done) state_next = S_WB;
      end
      S_WB: begin
        ctl.wb = sts.out_free;
        if (sts.out_free) state_next = S_IDLE;
      end
      default: state_next = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_CLEAR;
    else state <= state_next;
  end

  `ASSERT_CLK(a_accept_reads, clk, rst, (s_tvalid && s_tready) |=> (state == S_RD), "accepted item not read")
  `ASSERT_NEVER(a_wb_blocked, clk, rst, ctl.wb && !sts.out_free, "result written over pending one")
  `ASSERT_NEVER(a_div_stray, clk, rst, sts.div_done && (state != S_DV), "divider done outside wait")
endmodule

// ===== design/toy_register_machine_execute.sv =====
// top level of the register machine execute block: config register and wiring
// depends on trme_pkg, trme_ctrl, trme_dp
//
// channel  | dir | handshake         | payload
// s_*      | in  | tvalid/tready     | instruction item
// m_*      | out | tvalid/tready     | result item
// apb      | in  | psel/penable      | program_length at address 0
//
// an item passes through accept, register/memory read, execute and write back in turn
// DIV waits between execute and write back for the one-bit-per-cycle divider
// after reset a clear pass zeroes the data memory, no item taken
// a stalled result holds write back until the output register frees
module toy_register_machine_execute #(
  parameter int DATA_WORDS = trme_pkg::DATA_WORDS_DEF,
  parameter int REGISTER_COUNT = trme_pkg::REGISTER_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // cmd[3:0], target_reg[7:4], source_operand[39:8], read_value[71:40]
  input  logic [trme_pkg::IN_W-1:0]  s_tdata,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // next_pc[9:0], write_valid[10], write_value[42:11], halted[43], status[45:44],
  // executed_count[77:46]
  output logic [trme_pkg::OUT_W-1:0] m_tdata,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import trme_pkg::*;

  logic [PLEN_W-1:0] program_length;
  ctl_t ctl;
  sts_t sts;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PROGRAM_LENGTH) ? {21'd0, program_length} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) program_length <= PLEN_W'(PROGRAM_WORDS);
    else if (psel && penable && pwrite && (paddr[2] == REG_PROGRAM_LENGTH))
      program_length <= pwdata[PLEN_W-1:0];
  end

  trme_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .ctl      (ctl),
    .sts      (sts)
  );

  trme_dp #(
    .DATA_WORDS     (DATA_WORDS),
    .REGISTER_COUNT (REGISTER_COUNT)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .ctl            (ctl),
    .sts            (sts),
    .program_length (program_length),
    .s_tdata        (s_tdata),
    .m_tvalid       (m_tvalid),
    .m_tready       (m_tready),
    .m_tdata        (m_tdata)
  );
endmodule
